>>> src/lem_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lem_pkg
// Shared types, Q8.24 constants and rounding/saturation helpers for the
// D2Q9 equilibrium pipeline.
// ----------------------------------------------------------------------------
package lem_pkg;

  typedef logic signed [31:0] q_t;

  localparam int NUM_DIR = 9;
  localparam int MX_W    = 36;   // momentum width before division
  localparam int BETA_W  = 31;

  localparam q_t Q_ONE  = 32'sd16777216;
  localparam q_t Q_DIAG = 32'sd11863283;
  localparam logic [BETA_W-1:0] BETA_RST = 31'd50331648;

  // pipeline depths
  localparam int FRONT_LAT = 3;
  localparam int DIV_LAT   = 34;
  localparam int MID_LAT   = 4;
  localparam int LANE_LAT  = 9;
  localparam int DEPTH     = FRONT_LAT + DIV_LAT + MID_LAT + LANE_LAT;
  localparam int TAIL_LAT  = MID_LAT + LANE_LAT;

  // density and velocity carried alongside the lanes
  typedef struct packed {
    q_t rho;
    q_t ux;
    q_t uy;
  } moments_t;

  function automatic q_t sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // round-half-up Q8.24 product reduction, then saturate
  function automatic q_t rnd_sat(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + 64'sd8388608) >>> 24;
    return sat32(t);
  endfunction

  function automatic q_t weight(input logic [3:0] dir);
    case (dir)
      4'd0:                      return 32'sd7456540;
      4'd1, 4'd2, 4'd3, 4'd4:    return 32'sd1864135;
      default:                   return 32'sd466034;
    endcase
  endfunction

endpackage

>>> src/lattice_equilibrium_moments.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lattice_equilibrium_moments
// D2Q9 node moments and equilibrium populations in signed Q8.24.
// ----------------------------------------------------------------------------
//  channel | dir | signals                          | payload
//  in_     | in  | in_tvalid/in_tready/in_tdata     | pop_0..pop_8, 288 bits
//  out_    | out | out_tvalid/out_tready/out_tdata  | density, vel, feq, 384 bits
//  cfg_    | in  | cfg_wr_en/cfg_wr_data            | inverse_sound_speed_sq
//
//  One node per cycle while the output is not stalled: 3 front stages, 34 in the
//  one-bit-per-stage divider, 4 velocity stages and 9 in each equilibrium lane.
//  The whole pipeline advances when the output register is empty or taken.
//  rst_n (synchronous) clears the valid line and loads beta = 3.0.
// ----------------------------------------------------------------------------
module lattice_equilibrium_moments (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [287:0]  in_tdata,   // pop_0 .. pop_8, 32 bits each
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [383:0]  out_tdata,  // density, vel_x, vel_y, feq_0 .. feq_8
  input  logic          cfg_wr_en,
  input  logic [30:0]   cfg_wr_data
);

  localparam int ND = lem_pkg::NUM_DIR;

  logic pipe_en;
  logic [lem_pkg::DEPTH-1:0] vld_r, vld_nxt;
  logic [lem_pkg::BETA_W-1:0] beta_r, beta_nxt;

  lem_pkg::q_t p [0:ND-1];
  logic signed [35:0] sum;

  lem_pkg::q_t s1_rho_r, s2_rho_r, s3_rho_r;
  logic signed [32:0] s1_ax_r, s1_ay_r, s2_ax_r, s2_ay_r;
  logic signed [34:0] s1_dx_r, s1_dy_r;
  logic signed [63:0] s2_pdx_r, s2_pdy_r;
  logic signed [lem_pkg::MX_W-1:0] s3_mx_r, s3_my_r;

  lem_pkg::q_t div_ux, div_uy, div_rho;

  logic signed [63:0] pxx_r, pyy_r, pbu_r;
  logic signed [63:0] dp_r [5:8];
  lem_pkg::q_t sd_r [5:8];
  lem_pkg::q_t e1_d_r [1:4];
  lem_pkg::q_t e2_d_r [1:4];
  lem_pkg::q_t usq_r, bu_r;
  lem_pkg::q_t dot3_r [0:ND-1];
  lem_pkg::q_t dot4_r [0:ND-1];
  lem_pkg::q_t rho_e_r [1:4];
  lem_pkg::q_t feq [0:ND-1];
  lem_pkg::moments_t mom_r [0:lem_pkg::TAIL_LAT-1];
  logic signed [32:0] usq_sum;

  assign pipe_en   = !out_tvalid || out_tready;
  assign in_tready = pipe_en;

  always_comb begin
    for (int i = 0; i < ND; i++) p[i] = in_tdata[32*i +: 32];
    sum = 36'(p[0]) + 36'(p[1]) + 36'(p[2]) + 36'(p[3]) + 36'(p[4])
        + 36'(p[5]) + 36'(p[6]) + 36'(p[7]) + 36'(p[8]);
  end

  always_comb begin
    vld_nxt  = vld_r;
    beta_nxt = beta_r;
    if (pipe_en) vld_nxt = {vld_r[lem_pkg::DEPTH-2:0], in_tvalid};
    if (cfg_wr_en) beta_nxt = cfg_wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      beta_r <= lem_pkg::BETA_RST;
    end else begin
      vld_r  <= vld_nxt;
      beta_r <= beta_nxt;
    end
  end

  // front: density, axis and diagonal momentum
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_rho_r <= lem_pkg::sat32(64'(sum));
      s1_ax_r  <= 33'(p[1]) - 33'(p[3]);
      s1_ay_r  <= 33'(p[2]) - 33'(p[4]);
      s1_dx_r  <= 35'(p[5]) - 35'(p[6]) - 35'(p[7]) + 35'(p[8]);
      s1_dy_r  <= 35'(p[5]) + 35'(p[6]) - 35'(p[7]) - 35'(p[8]);
      s2_rho_r <= s1_rho_r;
      s2_ax_r  <= s1_ax_r;
      s2_ay_r  <= s1_ay_r;
      s2_pdx_r <= 64'(s1_dx_r) * 64'(lem_pkg::Q_DIAG);
      s2_pdy_r <= 64'(s1_dy_r) * 64'(lem_pkg::Q_DIAG);
      s3_rho_r <= s2_rho_r;
      s3_mx_r  <= 36'(s2_ax_r) + 36'((s2_pdx_r + 64'sd8388608) >>> 24);
      s3_my_r  <= 36'(s2_ay_r) + 36'((s2_pdy_r + 64'sd8388608) >>> 24);
    end
  end

  lem_div u_div (
    .clk   (clk),
    .en    (pipe_en),
    .num_x (s3_mx_r),
    .num_y (s3_my_r),
    .rho   (s3_rho_r),
    .ux    (div_ux),
    .uy    (div_uy),
    .rho_o (div_rho)
  );

  assign usq_sum = 33'(lem_pkg::rnd_sat(pxx_r)) + 33'(lem_pkg::rnd_sat(pyy_r));

  // velocity terms: |u|^2, beta |u|^2 and the nine c.u projections
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      pxx_r     <= div_ux * div_ux;
      pyy_r     <= div_uy * div_uy;
      sd_r[5]   <= lem_pkg::sat32(64'(div_ux) + 64'(div_uy));
      sd_r[6]   <= lem_pkg::sat32(64'(div_uy) - 64'(div_ux));
      sd_r[7]   <= lem_pkg::sat32(-64'(div_ux) - 64'(div_uy));
      sd_r[8]   <= lem_pkg::sat32(64'(div_ux) - 64'(div_uy));
      e1_d_r[1] <= div_ux;
      e1_d_r[2] <= div_uy;
      e1_d_r[3] <= lem_pkg::sat32(-64'(div_ux));
      e1_d_r[4] <= lem_pkg::sat32(-64'(div_uy));
      rho_e_r[1] <= div_rho;

      usq_r <= lem_pkg::sat32(64'(usq_sum));
      for (int i = 5; i <= 8; i++) dp_r[i] <= sd_r[i] * lem_pkg::Q_DIAG;
      for (int i = 1; i <= 4; i++) e2_d_r[i] <= e1_d_r[i];
      rho_e_r[2] <= rho_e_r[1];

      pbu_r     <= $signed({1'b0, beta_r}) * usq_r;
      dot3_r[0] <= '0;
      for (int i = 1; i <= 4; i++) dot3_r[i] <= e2_d_r[i];
      for (int i = 5; i <= 8; i++) dot3_r[i] <= lem_pkg::rnd_sat(dp_r[i]);
      rho_e_r[3] <= rho_e_r[2];

      bu_r <= lem_pkg::rnd_sat(pbu_r);
      for (int i = 0; i < ND; i++) dot4_r[i] <= dot3_r[i];
      rho_e_r[4] <= rho_e_r[3];

      mom_r[0] <= '{rho: div_rho, ux: div_ux, uy: div_uy};
      for (int k = 1; k < lem_pkg::TAIL_LAT; k++) mom_r[k] <= mom_r[k-1];
    end
  end

  for (genvar g = 0; g < ND; g++) begin : g_lane
    lem_lane u_lane (
      .clk  (clk),
      .en   (pipe_en),
      .beta (beta_r),
      .w    (lem_pkg::weight(4'(g))),
      .dot  (dot4_r[g]),
      .bu   (bu_r),
      .rho  (rho_e_r[4]),
      .feq  (feq[g])
    );
    assign out_tdata[96 + 32*g +: 32] = feq[g];
  end

  assign out_tdata[31:0]  = mom_r[lem_pkg::TAIL_LAT-1].rho;
  assign out_tdata[63:32] = mom_r[lem_pkg::TAIL_LAT-1].ux;
  assign out_tdata[95:64] = mom_r[lem_pkg::TAIL_LAT-1].uy;
  assign out_tvalid       = vld_r[lem_pkg::DEPTH-1];

`ifndef SYNTHESIS
  a_vel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ($signed(out_tdata[31:0]) <= 32'sd0) |->
      (out_tdata[63:32] == 32'd0) && (out_tdata[95:64] == 32'd0))
    else $error("velocity not zero for non-positive density");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(vld_r))
    else $error("pipeline moved while stalled");
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");
`endif

endmodule

>>> src/lem_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lem_div
// Two-lane pipelined restoring divider: velocity = momentum * 2^24 / rho,
// truncated toward zero and saturated; zero when rho is not positive.
// ----------------------------------------------------------------------------
module lem_div (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [lem_pkg::MX_W-1:0]  num_x,
  input  logic signed [lem_pkg::MX_W-1:0]  num_y,
  input  lem_pkg::q_t                      rho,
  output lem_pkg::q_t                      ux,
  output lem_pkg::q_t                      uy,
  output lem_pkg::q_t                      rho_o
);

  localparam int STEPS = lem_pkg::DIV_LAT - 2;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] low;
    logic [31:0] quo;
    logic        neg;
    logic        ovf;
  } lane_t;

  typedef struct packed {
    logic [30:0] den;
    logic        pos;
    lem_pkg::q_t rho;
  } com_t;

  lane_t st_x_r [0:STEPS];
  lane_t st_y_r [0:STEPS];
  com_t  com_r  [0:STEPS];
  lem_pkg::q_t ux_r, uy_r, rho_r;

  function automatic lane_t prep(input logic signed [lem_pkg::MX_W-1:0] n,
                                 input logic [30:0] den);
    lane_t s;
    logic [lem_pkg::MX_W-1:0] mag;
    mag   = n[lem_pkg::MX_W-1] ? lem_pkg::MX_W'(-n) : lem_pkg::MX_W'(n);
    s.rem = {4'd0, mag[35:8]};
    s.low = {mag[7:0], 24'd0};
    s.quo = '0;
    s.neg = n[lem_pkg::MX_W-1];
    s.ovf = s.rem >= {1'b0, den};
    return s;
  endfunction

  function automatic lane_t step(input lane_t s, input logic [30:0] den);
    lane_t o;
    logic [31:0] t;
    o = s;
    t = {s.rem[30:0], s.low[31]};
    o.low = {s.low[30:0], 1'b0};
    if (t >= {1'b0, den}) begin
      o.rem = t - {1'b0, den};
      o.quo = {s.quo[30:0], 1'b1};
    end else begin
      o.rem = t;
      o.quo = {s.quo[30:0], 1'b0};
    end
    return o;
  endfunction

  function automatic lem_pkg::q_t finish(input lane_t s, input logic pos);
    if (!pos) return '0;
    if (s.ovf) return s.neg ? 32'sh80000000 : 32'sh7fffffff;
    if (s.neg) return (s.quo > 32'h80000000) ? 32'sh80000000 : -$signed(s.quo);
    return s.quo[31] ? 32'sh7fffffff : $signed(s.quo);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      com_r[0].den <= rho[30:0];
      com_r[0].pos <= (rho > 32'sd0);
      com_r[0].rho <= rho;
      st_x_r[0]    <= prep(num_x, rho[30:0]);
      st_y_r[0]    <= prep(num_y, rho[30:0]);
      for (int k = 1; k <= STEPS; k++) begin
        com_r[k]  <= com_r[k-1];
        st_x_r[k] <= step(st_x_r[k-1], com_r[k-1].den);
        st_y_r[k] <= step(st_y_r[k-1], com_r[k-1].den);
      end
      ux_r  <= finish(st_x_r[STEPS], com_r[STEPS].pos);
      uy_r  <= finish(st_y_r[STEPS], com_r[STEPS].pos);
      rho_r <= com_r[STEPS].rho;
    end
  end

  assign ux    = ux_r;
  assign uy    = uy_r;
  assign rho_o = rho_r;

endmodule

>>> src/lem_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lem_lane
// One direction of the equilibrium: feq = rho * (w * (1 + cu + (cu^2 - bu)/2)).
// ----------------------------------------------------------------------------
module lem_lane (
  input  logic                          clk,
  input  logic                          en,
  input  logic [lem_pkg::BETA_W-1:0]    beta,
  input  lem_pkg::q_t                   w,
  input  lem_pkg::q_t                   dot,
  input  lem_pkg::q_t                   bu,
  input  lem_pkg::q_t                   rho,
  output lem_pkg::q_t                   feq
);

  logic signed [63:0] pcu_r, pcc_r, pwp_r, prf_r;
  lem_pkg::q_t cu2_r, cu3_r, cu4_r, diff_r, poly_r, wp_r, feq_r;
  lem_pkg::q_t bu1_r, bu2_r, bu3_r;
  lem_pkg::q_t rho1_r, rho2_r, rho3_r, rho4_r, rho5_r, rho6_r, rho7_r;
  lem_pkg::q_t beta_s;
  logic signed [33:0] poly_sum;
  logic signed [32:0] diff_sum;

  assign beta_s   = $signed({1'b0, beta});
  assign diff_sum = 33'(lem_pkg::rnd_sat(pcc_r)) - 33'(bu3_r);
  // half of diff with the product rounding is floor((diff + 1) / 2)
  assign poly_sum = 34'(lem_pkg::Q_ONE) + 34'(cu4_r) + ((34'(diff_r) + 34'sd1) >>> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      pcu_r  <= beta_s * dot;
      bu1_r  <= bu;
      rho1_r <= rho;
      cu2_r  <= lem_pkg::rnd_sat(pcu_r);
      bu2_r  <= bu1_r;
      rho2_r <= rho1_r;
      pcc_r  <= cu2_r * cu2_r;
      cu3_r  <= cu2_r;
      bu3_r  <= bu2_r;
      rho3_r <= rho2_r;
      diff_r <= lem_pkg::sat32(64'(diff_sum));
      cu4_r  <= cu3_r;
      rho4_r <= rho3_r;
      poly_r <= lem_pkg::sat32(64'(poly_sum));
      rho5_r <= rho4_r;
      pwp_r  <= w * poly_r;
      rho6_r <= rho5_r;
      wp_r   <= lem_pkg::rnd_sat(pwp_r);
      rho7_r <= rho6_r;
      prf_r  <= rho7_r * wp_r;
      feq_r  <= lem_pkg::rnd_sat(prf_r);
    end
  end

  assign feq = feq_r;

endmodule
